FILE: design/mrm_pkg.sv
// mrm_pkg: shared constants, types and the destination scale table for the
// modulation routing matrix. No dependencies.
package mrm_pkg;

    localparam int MAX_ROWS      = 4;
    localparam int ROW_COUNT_DEF = 4;
    localparam int DEST_COUNT    = 13;
    localparam int DEST_LAST     = DEST_COUNT - 1;

    localparam int SRC_W      = 16;
    localparam int DEPTH_W    = 16;
    localparam int TGT_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DEST_W     = 4;
    localparam int VAL_W      = 32;

    localparam int SCALE_W     = 14;
    localparam int PROD_W      = SRC_W + DEPTH_W;
    localparam int SCALED_W    = PROD_W + SCALE_W + 1;
    localparam int PAIR_W      = SCALED_W + 1;
    localparam int SUM_W       = PAIR_W + 1;
    localparam int ROUND_SHIFT = 22;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'sd1 <<< (ROUND_SHIFT - 1));

    // register index map
    localparam int CFG_DEPTH_BASE  = 0;
    localparam int CFG_TARGET_BASE = MAX_ROWS;

    typedef logic signed [SRC_W-1:0]    t_sample;
    typedef logic signed [DEPTH_W-1:0]  t_depth;
    typedef logic [TGT_W-1:0]           t_target;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [SCALED_W-1:0] t_term;
    typedef logic signed [PAIR_W-1:0]   t_pair;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic [DEST_W-1:0]          t_dest;

    // unsigned Q6.8 destination scales, zero for destinations that do not exist
    function automatic logic [SCALE_W-1:0] scale_q8_8(input t_target dest);
        logic [SCALE_W-1:0] s;
        case (dest)
            4'd0:    s = 14'd1280;
            4'd1:    s = 14'd6912;
            4'd3:    s = 14'd8730;
            4'd8:    s = 14'd2842;
            4'd10:   s = 14'd3610;
            4'd2, 4'd4, 4'd5, 4'd6, 4'd7, 4'd9, 4'd11, 4'd12: s = 14'd256;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

FILE: design/mrm_if.sv
// mrm_if: valid/ready channel interfaces for source frames and destination sums.
// Depends on mrm_pkg.
interface mrm_in_if import mrm_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample source_0;
    t_sample source_1;
    t_sample source_2;
    t_sample source_3;

    modport source (output valid, output source_0, output source_1, output source_2,
                    output source_3, input ready);
    modport sink   (input valid, input source_0, input source_1, input source_2,
                    input source_3, output ready);
endinterface

interface mrm_out_if import mrm_pkg::*; ();
    logic               valid;
    logic               ready;
    t_dest              dest_index;
    logic signed [VAL_W-1:0] dest_value;
    logic               last;

    modport source (output valid, output dest_index, output dest_value, output last,
                    input ready);
    modport sink   (input valid, input dest_index, input dest_value, input last,
                    output ready);
endinterface

FILE: design/modulation_routing_matrix_unit.sv
// the first sum of a frame passes stages 1 and 2, the frame buffer and stage 4 into the
// output register, the other twelve follow one per cycle unless the output stalls, last
// flag on destination 12; a new frame enters the serializer as it emits the last sum;
// both multiply stages, unless stalled, take an item per cycle and hold up to two frames
// reset (synchronous, active low) clears all valid bits and the depth and target registers
// modulation routing matrix top level; depends on mrm_pkg and mrm_if
module modulation_routing_matrix_unit import mrm_pkg::*; #(
    parameter int ROW_COUNT = ROW_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mrm_in_if.sink                i_in,
    mrm_out_if.source             o_out
);

    t_sample w_src [MAX_ROWS];
    assign w_src[0] = i_in.source_0;
    assign w_src[1] = i_in.source_1;
    assign w_src[2] = i_in.source_2;
    assign w_src[3] = i_in.source_3;

    // configuration registers
    t_depth  r_depth  [ROW_COUNT];
    t_target r_target [ROW_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < ROW_COUNT; r++) begin
                r_depth[r]  <= '0;
                r_target[r] <= '0;
            end
        end else if (i_cfg_we) begin
            for (int r = 0; r < ROW_COUNT; r++) begin
                if (i_cfg_index == CFG_IDX_W'(CFG_DEPTH_BASE + r)) begin
                    r_depth[r] <= t_depth'(i_cfg_data);
                end
                if (i_cfg_index == CFG_IDX_W'(CFG_TARGET_BASE + r)) begin
                    r_target[r] <= i_cfg_data[TGT_W-1:0];
                end
            end
        end
    end

    // handshake chain, each stage takes when empty or when its content moves on
    logic s1_take, s2_take, s3_free, s3_load, s3_emit, s4_take, out_take;

    logic    r_s1_valid;
    t_prod   r_s1_prod [ROW_COUNT];
    t_target r_s1_tgt  [ROW_COUNT];

    logic    r_s2_valid;
    t_term   r_s2_term [ROW_COUNT];
    t_target r_s2_tgt  [ROW_COUNT];

    logic    r_s3_busy;
    t_dest   r_s3_dest;
    t_term   r_s3_term [ROW_COUNT];
    t_target r_s3_tgt  [ROW_COUNT];

    logic    r_s4_valid;
    t_pair   r_s4_even;
    t_pair   r_s4_odd;
    t_dest   r_s4_dest;
    logic    r_s4_last;

    logic                    r_out_valid;
    t_dest                   r_out_index;
    logic signed [VAL_W-1:0] r_out_value;
    logic                    r_out_last;

    assign out_take = !r_out_valid || o_out.ready;
    assign s4_take  = !r_s4_valid || out_take;
    assign s3_emit  = r_s3_busy && s4_take;
    assign s3_free  = !r_s3_busy || (s3_emit && r_s3_dest == DEST_W'(DEST_LAST));
    assign s3_load  = r_s2_valid && s3_free;
    assign s2_take  = !r_s2_valid || s3_free;
    assign s1_take  = !r_s1_valid || s2_take;

    assign i_in.ready = s1_take;

    // stage 1: source times depth per row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_take) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take && i_in.valid) begin
            for (int r = 0; r < ROW_COUNT; r++) begin
                r_s1_prod[r] <= w_src[r] * r_depth[r];
                r_s1_tgt[r]  <= r_target[r];
            end
        end
    end

    // stage 2: times destination scale, targets past the table scale by zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_take) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_take && r_s1_valid) begin
            for (int r = 0; r < ROW_COUNT; r++) begin
                r_s2_term[r] <= r_s1_prod[r] * $signed({1'b0, scale_q8_8(r_s1_tgt[r])});
                r_s2_tgt[r]  <= r_s1_tgt[r];
            end
        end
    end

    // stage 3: frame buffer and destination counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_busy <= 1'b0;
            r_s3_dest <= '0;
        end else if (s3_load) begin
            r_s3_busy <= 1'b1;
            r_s3_dest <= '0;
        end else if (s3_emit) begin
            if (r_s3_dest == DEST_W'(DEST_LAST)) begin
                r_s3_busy <= 1'b0;
            end else begin
                r_s3_dest <= r_s3_dest + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_load) begin
            r_s3_term <= r_s2_term;
            r_s3_tgt  <= r_s2_tgt;
        end
    end

    // stage 4: rows routed to the current destination, summed in two halves
    t_pair n_s4_even, n_s4_odd;

    always_comb begin
        n_s4_even = '0;
        n_s4_odd  = '0;
        for (int r = 0; r < ROW_COUNT; r++) begin
            if (TGT_W'(r_s3_dest) == r_s3_tgt[r]) begin
                if (r % 2 == 0) begin
                    n_s4_even = n_s4_even + PAIR_W'(r_s3_term[r]);
                end else begin
                    n_s4_odd = n_s4_odd + PAIR_W'(r_s3_term[r]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (s4_take) begin
            r_s4_valid <= r_s3_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_emit) begin
            r_s4_even <= n_s4_even;
            r_s4_odd  <= n_s4_odd;
            r_s4_dest <= r_s3_dest;
            r_s4_last <= (r_s3_dest == DEST_W'(DEST_LAST));
        end
    end

    // stage 5: final add, round half up to an integer, dropping all 22 fraction bits
    t_sum n_sum;
    assign n_sum = SUM_W'(r_s4_even) + SUM_W'(r_s4_odd) + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_take) begin
            r_out_valid <= r_s4_valid;
        end
    end

    // the rounded sum spans at most 27 bits, so the 32-bit range never clips
    always_ff @(posedge i_clk) begin
        if (out_take && r_s4_valid) begin
            r_out_index <= r_s4_dest;
            r_out_value <= VAL_W'($signed(n_sum[SUM_W-1:ROUND_SHIFT]));
            r_out_last  <= r_s4_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.dest_index = r_out_index;
    assign o_out.dest_value = r_out_value;
    assign o_out.last       = r_out_last;

    a_last_on_final_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last) |-> (o_out.dest_index == DEST_W'(DEST_LAST)))
        else $error("last flag on a destination other than the final one");

    a_dest_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_busy |-> (r_s3_dest <= DEST_W'(DEST_LAST)))
        else $error("destination counter out of range");

    a_s1_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_take) |=> r_s1_valid)
        else $error("stalled stage 1 item dropped");

    a_frame_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s3_emit && r_s3_dest == DEST_W'(DEST_LAST) && !r_s2_valid) |=> !r_s3_busy)
        else $error("serializer still busy after the final destination");

    a_new_frame_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s3_load |=> (r_s3_busy && r_s3_dest == '0))
        else $error("frame did not start at destination zero");

endmodule

FILE: tb/sv/modulation_routing_matrix_unit_tb.sv
// modulation_routing_matrix_unit_tb: self-checking bench for the modulation routing matrix.
// Drives source frames and row registers, predicts the 13 destination sums per frame.
// Depends on mrm_pkg, mrm_if and modulation_routing_matrix_unit.
module modulation_routing_matrix_unit_tb;
    import mrm_pkg::*;

    localparam int ROWS_ACTIVE = ROW_COUNT_DEF;
    localparam int FRAC_DROP   = 22;
    localparam int MAX_REPORTS = 10;

    localparam t_sample SAMPLE_MAX = 16'sh7fff;
    localparam t_sample SAMPLE_MIN = 16'sh8000;
    localparam t_depth  DEPTH_MAX  = 16'sh7fff;
    localparam t_depth  DEPTH_MIN  = 16'sh8000;
    localparam t_depth  DEPTH_ONE  = 16'sh4000;
    localparam t_depth  DEPTH_NEG1 = -16'sh4000;

    localparam t_target DEST_PITCH  = 4'd0;
    localparam t_target DEST_SCALE2 = 4'd1;
    localparam t_target DEST_SCALE3 = 4'd3;
    localparam t_target DEST_SCALE4 = 4'd8;
    localparam t_target DEST_SCALE5 = 4'd10;
    localparam t_target DEST_FINAL  = 4'd12;
    localparam t_target DEST_NONE13 = 4'd13;
    localparam t_target DEST_NONE14 = 4'd14;
    localparam t_target DEST_NONE15 = 4'd15;

    typedef struct packed {
        t_dest                   idx;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } t_sum_rec;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mrm_in_if  frame_if ();
    mrm_out_if sum_if ();

    modulation_routing_matrix_unit #(
        .ROW_COUNT(ROWS_ACTIVE)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in       (frame_if),
        .o_out      (sum_if)
    );

    // shadow of the row registers
    t_depth   row_depth [MAX_ROWS];
    t_target  row_target [MAX_ROWS];
    t_sum_rec sums_due [$];
    int       fail_count = 0;
    bit       calm = 0;
    int       idle_pct = 30;
    int       stall_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint dest_gain(input t_target d);
        case (d)
            4'd0:    return 1280;
            4'd1:    return 6912;
            4'd3:    return 8730;
            4'd8:    return 2842;
            4'd10:   return 3610;
            default: return 256;
        endcase
    endfunction

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic t_depth pick_depth();
        case ($urandom_range(0, 9))
            0:       return DEPTH_MAX;
            1:       return DEPTH_MIN;
            2:       return DEPTH_ONE;
            3:       return DEPTH_NEG1;
            4:       return t_depth'($urandom_range(0, 32768)) - DEPTH_ONE;
            default: return t_depth'($urandom);
        endcase
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
    endtask

    // expected sums for one accepted frame under the current row registers
    task automatic predict_frame(input t_sample s0, input t_sample s1,
                                 input t_sample s2, input t_sample s3);
        t_sample  src [MAX_ROWS];
        longint   acc [DEST_COUNT];
        longint   q;
        t_sum_rec rec;
        src[0] = s0;
        src[1] = s1;
        src[2] = s2;
        src[3] = s3;
        for (int d = 0; d < DEST_COUNT; d++) begin
            acc[d] = 0;
        end
        for (int r = 0; r < ROWS_ACTIVE; r++) begin
            if (row_target[r] < DEST_COUNT) begin
                acc[row_target[r]] += longint'(src[r]) * longint'(row_depth[r])
                                      * dest_gain(row_target[r]);
            end
        end
        for (int d = 0; d < DEST_COUNT; d++) begin
            // round half up, then floor
            q = (acc[d] + (longint'(1) <<< (FRAC_DROP - 1))) >>> FRAC_DROP;
            if (q > longint'(32'sh7fffffff)) begin
                q = longint'(32'sh7fffffff);
            end else if (q < -longint'(32'sh7fffffff) - 1) begin
                q = -longint'(32'sh7fffffff) - 1;
            end
            rec.idx   = t_dest'(d);
            rec.value = q[VAL_W-1:0];
            rec.last  = (d == DEST_LAST);
            sums_due.push_back(rec);
        end
    endtask

    task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = CFG_IDX_W'(idx);
        cfg_data  = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
        if (idx < CFG_TARGET_BASE) begin
            row_depth[idx - CFG_DEPTH_BASE] = t_depth'(data);
        end else begin
            row_target[idx - CFG_TARGET_BASE] = data[TGT_W-1:0];
        end
    endtask

    task automatic set_row(input int r, input t_depth depth, input t_target tgt);
        write_reg(CFG_DEPTH_BASE + r, depth);
        // upper data bits are junk the target register must drop
        write_reg(CFG_TARGET_BASE + r, {12'($urandom), tgt});
    endtask

    // valid stays high after acceptance; a drain, or an idle gap in the next call, lowers it
    task automatic send_frame(input t_sample s0, input t_sample s1,
                              input t_sample s2, input t_sample s3);
        if (!calm && $urandom_range(1, 100) <= idle_pct) begin
            frame_if.valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        frame_if.valid    = 1'b1;
        frame_if.source_0 = s0;
        frame_if.source_1 = s1;
        frame_if.source_2 = s2;
        frame_if.source_3 = s3;
        do @(posedge i_clk); while (frame_if.ready !== 1'b1);
        predict_frame(s0, s1, s2, s3);
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        frame_if.valid = 1'b0;
        while (sums_due.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic test_reset_values();
        send_frame(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
        send_frame(SAMPLE_MIN, SAMPLE_MAX, '0, -16'sd1);
        wait_for_drain();
    endtask

    task automatic test_extremes();
        set_row(0, DEPTH_MAX, DEST_PITCH);
        set_row(1, DEPTH_MIN, DEST_SCALE2);
        set_row(2, DEPTH_ONE, DEST_SCALE3);
        set_row(3, DEPTH_NEG1, DEST_SCALE5);
        send_frame(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        send_frame(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
        send_frame(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
        send_frame('0, -16'sd1, 16'sd1, '0);
        wait_for_drain();
        // all rows pile onto the largest scale
        for (int r = 0; r < MAX_ROWS; r++) begin
            set_row(r, DEPTH_MIN, DEST_SCALE3);
        end
        send_frame(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
        wait_for_drain();
    endtask

    task automatic test_unused_targets();
        set_row(0, DEPTH_MAX, DEST_NONE13);
        set_row(1, DEPTH_MIN, DEST_NONE14);
        set_row(2, DEPTH_ONE, DEST_NONE15);
        set_row(3, DEPTH_NEG1, DEST_FINAL);
        repeat (3) send_frame(pick_sample(), pick_sample(), pick_sample(), pick_sample());
        wait_for_drain();
    endtask

    task automatic test_each_destination();
        set_row(2, DEPTH_ONE, DEST_NONE15);
        set_row(3, DEPTH_MAX, DEST_SCALE4);
        write_reg(CFG_DEPTH_BASE, DEPTH_ONE);
        write_reg(CFG_DEPTH_BASE + 1, DEPTH_NEG1);
        for (int d = 0; d < DEST_COUNT; d++) begin
            write_reg(CFG_TARGET_BASE, CFG_DATA_W'(t_target'(d)));
            write_reg(CFG_TARGET_BASE + 1,
                      CFG_DATA_W'(t_target'((d + 5) % DEST_COUNT)));
            send_frame(SAMPLE_MAX, pick_sample(), pick_sample(), pick_sample());
            wait_for_drain();
        end
    endtask

    task automatic test_random_traffic();
        t_target tgt;
        for (int phase = 0; phase < 8; phase++) begin
            calm     = (phase == 7);
            idle_pct = (phase == 2) ? 0 : $urandom_range(10, 50);
            for (int r = 0; r < MAX_ROWS; r++) begin
                tgt = ($urandom_range(0, 7) == 0) ? t_target'($urandom_range(13, 15))
                                                  : t_target'($urandom_range(0, 12));
                set_row(r, pick_depth(), tgt);
            end
            for (int n = 0; n < 25; n++) begin
                send_frame(pick_sample(), pick_sample(), pick_sample(), pick_sample());
                if (phase == 4 && n == 12) begin
                    wait_for_drain();
                end
            end
            wait_for_drain();
        end
    endtask

    // sink side stalls in bursts
    initial begin
        sum_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm) begin
                stall_left   = 0;
                sum_if.ready = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                sum_if.ready = 1'b0;
            end else if ($urandom_range(1, 100) <= idle_pct / 3) begin
                stall_left   = $urandom_range(1, 19) - 1;
                sum_if.ready = 1'b0;
            end else begin
                sum_if.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_sum_rec want;
        if (i_rst_n === 1'b1 && sum_if.valid === 1'b1 && sum_if.ready === 1'b1) begin
            if (sums_due.size() == 0) begin
                note_failure($sformatf("unexpected sum dest %0d value %0d",
                                       sum_if.dest_index, sum_if.dest_value));
            end else begin
                want = sums_due.pop_front();
                if (sum_if.dest_index !== want.idx || sum_if.dest_value !== want.value
                        || sum_if.last !== want.last) begin
                    note_failure($sformatf("expected dest %0d value %0d last %0b, got %0d %0d %0b",
                                           want.idx, want.value, want.last,
                                           sum_if.dest_index, sum_if.dest_value,
                                           sum_if.last));
                end
            end
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        frame_if.valid    = 1'b0;
        frame_if.source_0 = '0;
        frame_if.source_1 = '0;
        frame_if.source_2 = '0;
        frame_if.source_3 = '0;
        for (int r = 0; r < MAX_ROWS; r++) begin
            row_depth[r]  = '0;
            row_target[r] = '0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_extremes();
        test_unused_targets();
        test_each_destination();
        test_random_traffic();

        wait_for_drain();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
